[hdl/rfue_pkg.sv]
// rfue_pkg: shared types, constants and calendar tables for the rtc to epoch converter
// no dependencies; imported by rfue_front, rfue_queue, rfue_back and the top level

package rfue_pkg;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // calendar constants
    localparam logic [14:0] EPOCH_YEAR    = 15'd1970;
    localparam logic [14:0] MAX_YEAR      = 15'd9999;
    localparam logic [14:0] DEFAULT_CENT  = 15'd2000;
    localparam logic [12:0] LEAP_OFFSET   = 13'd477;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

    // status register b bits
    localparam int STAT_BINARY = 2;
    localparam int STAT_24H    = 1;
    localparam int HOUR_PM_BIT = 7;

    // decoded and classified request, front to back
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  mon;
        logic [4:0]  day;
        logic [4:0]  hr;
        logic [5:0]  min;
        logic [5:0]  sec;
        logic        leap;
        logic [6:0]  qpy;      // (year - 1) / 100
        logic        invalid;
    } t_item;

    // low nibble plus ten times high nibble, bad digits decoded the same way
    function automatic logic [7:0] dec_bcd(input logic [7:0] v);
        dec_bcd = {4'b0, v[3:0]} + {1'b0, v[7:4], 3'b0} + {3'b0, v[7:4], 1'b0};
    endfunction

    // days in month for a common year
    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd2:                      month_len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    // days before the first of the month for a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        case (m)
            4'd2:    cum_days = 9'd31;
            4'd3:    cum_days = 9'd59;
            4'd4:    cum_days = 9'd90;
            4'd5:    cum_days = 9'd120;
            4'd6:    cum_days = 9'd151;
            4'd7:    cum_days = 9'd181;
            4'd8:    cum_days = 9'd212;
            4'd9:    cum_days = 9'd243;
            4'd10:   cum_days = 9'd273;
            4'd11:   cum_days = 9'd304;
            4'd12:   cum_days = 9'd334;
            default: cum_days = 9'd0;
        endcase
    endfunction

endpackage

[hdl/rfue_front.sv]
// rfue_front: accepts raw rtc register sets, decodes bcd and 12-hour time, builds the year
// and classifies the request as valid or invalid; depends on rfue_pkg

module rfue_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_century_present,
    input  logic                i_vld,
    output logic                o_rdy,
    input  logic [55:0]         i_data,     // sec, min, hours, day, month, year, century
    input  logic [7:0]          i_status,
    output logic                o_wr_vld,
    input  logic                i_wr_rdy,
    output rfue_pkg::t_item     o_wr_item
);
    import rfue_pkg::*;

    // stage 1: field decode and year
    logic        bcd;
    logic [7:0]  d_sec, d_min, d_day, d_mon, d_yr, d_cen, raw_cen;
    logic [7:0]  d_hr8;
    logic [14:0] cen_x100;
    logic [14:0] n_s1_year;

    logic        r_s1_vld;
    logic [7:0]  r_s1_sec, r_s1_min, r_s1_day, r_s1_mon;
    logic [6:0]  r_s1_hr;
    logic [14:0] r_s1_year;
    logic        r_s1_pm, r_s1_h12;

    // stage 2: hour fold, year and field range checks, quotient by 100
    logic [12:0] hq_prod;
    logic [3:0]  hq;
    logic [6:0]  hmod;
    logic [6:0]  hr24;
    logic [27:0] q_prod;
    logic [8:0]  q100;
    logic        n_s2_bad;

    logic        r_s2_vld;
    logic [13:0] r_s2_year;
    logic [6:0]  r_s2_q100;
    logic [3:0]  r_s2_mon;
    logic [7:0]  r_s2_day;
    logic [4:0]  r_s2_hr;
    logic [5:0]  r_s2_min, r_s2_sec;
    logic        r_s2_bad;

    // stage 3: leap year and day check
    logic [13:0] q_x100;
    logic        r100z;
    logic        leap;
    logic [4:0]  mdays;
    logic        day_bad;

    logic s1_rdy, s2_rdy;

    assign s2_rdy = !r_s2_vld || i_wr_rdy;
    assign s1_rdy = !r_s1_vld || s2_rdy;
    assign o_rdy  = s1_rdy;

    always_comb begin
        bcd     = !i_status[STAT_BINARY];
        raw_cen = i_century_present ? i_data[55:48] : 8'd0;
        d_sec   = bcd ? dec_bcd(i_data[7:0])   : i_data[7:0];
        d_min   = bcd ? dec_bcd(i_data[15:8])  : i_data[15:8];
        d_hr8   = bcd ? dec_bcd({1'b0, i_data[22:16]}) : {1'b0, i_data[22:16]};
        d_day   = bcd ? dec_bcd(i_data[31:24]) : i_data[31:24];
        d_mon   = bcd ? dec_bcd(i_data[39:32]) : i_data[39:32];
        d_yr    = bcd ? dec_bcd(i_data[47:40]) : i_data[47:40];
        d_cen   = bcd ? dec_bcd(raw_cen)       : raw_cen;
        cen_x100 = {1'b0, d_cen, 6'b0} + {2'b0, d_cen, 5'b0} + {5'b0, d_cen, 2'b0};
        if (d_cen != 8'd0) begin
            n_s1_year = cen_x100 + 15'(d_yr);
        end else begin
            n_s1_year = DEFAULT_CENT + 15'(d_yr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_sec  <= d_sec;
            r_s1_min  <= d_min;
            r_s1_hr   <= d_hr8[6:0];
            r_s1_day  <= d_day;
            r_s1_mon  <= d_mon;
            r_s1_year <= n_s1_year;
            r_s1_pm   <= i_data[16 + HOUR_PM_BIT];
            r_s1_h12  <= !i_status[STAT_24H];
        end
    end

    always_comb begin
        // hour / 12 by reciprocal, exact for 7-bit hours
        hq_prod = 13'(r_s1_hr) * 13'd43;
        hq      = hq_prod[12:9];
        hmod    = r_s1_hr - 7'({hq, 3'b0} + {1'b0, hq, 2'b0});
        if (r_s1_h12) begin
            hr24 = hmod + (r_s1_pm ? 7'd12 : 7'd0);
        end else begin
            hr24 = r_s1_hr;
        end
        // year / 100 by reciprocal, exact below 16666
        q_prod = 28'(r_s1_year) * 28'd5243;
        q100   = q_prod[27:19];
        n_s2_bad = (r_s1_year < EPOCH_YEAR) || (r_s1_year > MAX_YEAR) ||
                   (r_s1_mon < 8'd1) || (r_s1_mon > 8'd12) || (hr24 > 7'd23) ||
                   (r_s1_min > 8'd59) || (r_s1_sec > 8'd59);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_year <= r_s1_year[13:0];
            r_s2_q100 <= q100[6:0];
            r_s2_mon  <= r_s1_mon[3:0];
            r_s2_day  <= r_s1_day;
            r_s2_hr   <= hr24[4:0];
            r_s2_min  <= r_s1_min[5:0];
            r_s2_sec  <= r_s1_sec[5:0];
            r_s2_bad  <= n_s2_bad;
        end
    end

    always_comb begin
        q_x100  = {1'b0, r_s2_q100, 6'b0} + {2'b0, r_s2_q100, 5'b0} + {5'b0, r_s2_q100, 2'b0};
        r100z   = (r_s2_year == q_x100);
        leap    = (r_s2_year[1:0] == 2'b00) && (!r100z || (r_s2_q100[1:0] == 2'b00));
        mdays   = month_len(r_s2_mon) + ((r_s2_mon == 4'd2 && leap) ? 5'd1 : 5'd0);
        day_bad = (r_s2_day == 8'd0) || (r_s2_day > 8'(mdays));

        o_wr_item.year    = r_s2_year;
        o_wr_item.mon     = r_s2_mon;
        o_wr_item.day     = r_s2_day[4:0];
        o_wr_item.hr      = r_s2_hr;
        o_wr_item.min     = r_s2_min;
        o_wr_item.sec     = r_s2_sec;
        o_wr_item.leap    = leap;
        o_wr_item.qpy     = r100z ? (r_s2_q100 - 7'd1) : r_s2_q100;
        o_wr_item.invalid = r_s2_bad || day_bad;
    end

    assign o_wr_vld = r_s2_vld;

endmodule

[hdl/rfue_queue.sv]
// rfue_queue: small register queue of classified requests between front and back
// depends on rfue_pkg

module rfue_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_vld,
    output logic                o_wr_rdy,
    input  rfue_pkg::t_item     i_wr_item,
    output logic                o_rd_vld,
    input  logic                i_rd_rdy,
    output rfue_pkg::t_item     o_rd_item
);
    import rfue_pkg::*;

    t_item               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                wr_en, rd_en;

    assign o_wr_rdy  = (r_count != QCNT_W'(QDEPTH));
    assign o_rd_vld  = (r_count != '0);
    assign wr_en     = i_wr_vld && o_wr_rdy;
    assign rd_en     = o_rd_vld && i_rd_rdy;
    assign o_rd_item = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(wr_en) - QCNT_W'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            r_count == $past(r_count) + QCNT_W'($past(wr_en)) - QCNT_W'($past(rd_en)))
        else $error("queue count out of step with pushes and pops");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != QCNT_W'(QDEPTH)) |-> (r_wptr - r_rptr) == r_count[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

[hdl/rfue_back.sv]
// rfue_back: four-stage pipeline that turns a classified request into epoch seconds
// depends on rfue_pkg

module rfue_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_vld,
    output logic                o_rd_rdy,
    input  rfue_pkg::t_item     i_item,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [39:0]         o_tdata,    // epoch_seconds[37:0], two zero bits
    output logic                o_tuser     // invalid
);
    import rfue_pkg::*;

    logic b1_rdy, b2_rdy, b3_rdy, b4_rdy;

    // stage 1: year and time products, leap days and day of year
    logic [13:0] yoff, py;
    logic [22:0] m365_prod;
    logic [12:0] lc;
    logic [8:0]  mo;
    logic [16:0] h3600;
    logic [11:0] m60;

    logic        r_b1_vld;
    logic [21:0] r_b1_m365;
    logic [11:0] r_b1_lc;
    logic [8:0]  r_b1_mo;
    logic [16:0] r_b1_h3600;
    logic [11:0] r_b1_m60;
    logic [5:0]  r_b1_sec;
    logic        r_b1_inv;

    // stage 2: day count and seconds of day
    logic        r_b2_vld;
    logic [21:0] r_b2_days;
    logic [16:0] r_b2_hms;
    logic        r_b2_inv;

    // stage 3: days times seconds per day
    logic [38:0] dprod;
    logic        r_b3_vld;
    logic [37:0] r_b3_dsec;
    logic [16:0] r_b3_hms;
    logic        r_b3_inv;

    // stage 4: final sum and output register
    logic        r_b4_vld;
    logic [37:0] r_b4_epoch;
    logic        r_b4_inv;

    assign b4_rdy   = !r_b4_vld || i_tready;
    assign b3_rdy   = !r_b3_vld || b4_rdy;
    assign b2_rdy   = !r_b2_vld || b3_rdy;
    assign b1_rdy   = !r_b1_vld || b2_rdy;
    assign o_rd_rdy = b1_rdy;

    always_comb begin
        yoff      = i_item.year - EPOCH_YEAR[13:0];
        py        = i_item.year - 14'd1;
        m365_prod = 23'(yoff) * 23'd365;
        // leap days before this year, counted from 1970
        lc        = 13'(py[13:2]) + 13'(i_item.qpy[6:2]) - 13'(i_item.qpy) - LEAP_OFFSET;
        mo        = cum_days(i_item.mon) + 9'(i_item.day) - 9'd1 +
                    ((i_item.mon > 4'd2 && i_item.leap) ? 9'd1 : 9'd0);
        h3600     = 17'(i_item.hr) * 17'(SEC_PER_HOUR);
        m60       = 12'(i_item.min) * 12'(SEC_PER_MIN);
        dprod     = 39'(r_b2_days) * 39'(SEC_PER_DAY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
        end else begin
            if (b1_rdy) begin
                r_b1_vld <= i_rd_vld;
            end
            if (b2_rdy) begin
                r_b2_vld <= r_b1_vld;
            end
            if (b3_rdy) begin
                r_b3_vld <= r_b2_vld;
            end
            if (b4_rdy) begin
                r_b4_vld <= r_b3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_rdy) begin
            r_b1_m365  <= m365_prod[21:0];
            r_b1_lc    <= lc[11:0];
            r_b1_mo    <= mo;
            r_b1_h3600 <= h3600;
            r_b1_m60   <= m60;
            r_b1_sec   <= i_item.sec;
            r_b1_inv   <= i_item.invalid;
        end
        if (b2_rdy) begin
            r_b2_days <= r_b1_m365 + 22'(r_b1_lc) + 22'(r_b1_mo);
            r_b2_hms  <= r_b1_h3600 + 17'(r_b1_m60) + 17'(r_b1_sec);
            r_b2_inv  <= r_b1_inv;
        end
        if (b3_rdy) begin
            r_b3_dsec <= dprod[37:0];
            r_b3_hms  <= r_b2_hms;
            r_b3_inv  <= r_b2_inv;
        end
        if (b4_rdy) begin
            r_b4_epoch <= r_b3_inv ? 38'd0 : (r_b3_dsec + 38'(r_b3_hms));
            r_b4_inv   <= r_b3_inv;
        end
    end

    assign o_tvalid = r_b4_vld;
    assign o_tdata  = {2'b00, r_b4_epoch};
    assign o_tuser  = r_b4_inv;

endmodule

[hdl/rtc_fields_to_unix_epoch.sv]
// rtc_fields_to_unix_epoch: top level of the rtc register set to unix epoch converter
// depends on rfue_pkg, rfue_front, rfue_queue and rfue_back

// Converts one snapshot of cmos clock registers per request into seconds since
// 1970-01-01 00:00:00. Status bit 2 clear selects bcd decode of every byte, status
// bit 1 clear selects 12-hour time with the pm flag in hour bit 7. The year is
// century*100+year when a century register is present (i_cfg_wdata written as 1)
// and decodes nonzero, else 2000+year. Out-of-range dates and times, and years
// outside 1970..9999, come out with tuser set and tdata zero. The block takes one
// request per clock and returns one result per clock while the result side does not
// stall; each request passes in turn through seven register stages: two front register
// stages, one queue slot and four back pipeline stages (the back multiplier stage for
// days times 86400 is one of them). A four-entry queue lets the front keep accepting
// while the result side stalls, until the queue fills. Write the century setting only
// while no request is in flight.

module rtc_fields_to_unix_epoch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // century_present
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,    // raw_seconds, raw_minutes, raw_hours, raw_day,
                                         // raw_month, raw_year, raw_century
    input  logic [7:0]  s_axis_tuser,    // status_b
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // epoch_seconds[37:0], two zero pad bits
    output logic        m_axis_tuser     // invalid
);
    import rfue_pkg::*;

    // century register presence setting
    logic  r_century_present;

    // front to queue
    logic  f_wr_vld, q_wr_rdy;
    t_item f_item;

    // queue to back
    logic  q_rd_vld, b_rd_rdy;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_century_present <= 1'b0;
        end else if (i_cfg_we) begin
            r_century_present <= i_cfg_wdata;
        end
    end

    // decode, year build and range classification
    rfue_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_century_present (r_century_present),
        .i_vld             (s_axis_tvalid),
        .o_rdy             (s_axis_tready),
        .i_data            (s_axis_tdata),
        .i_status          (s_axis_tuser),
        .o_wr_vld          (f_wr_vld),
        .i_wr_rdy          (q_wr_rdy),
        .o_wr_item         (f_item)
    );

    // decouples front and back so each stalls on its own
    rfue_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_vld  (f_wr_vld),
        .o_wr_rdy  (q_wr_rdy),
        .i_wr_item (f_item),
        .o_rd_vld  (q_rd_vld),
        .i_rd_rdy  (b_rd_rdy),
        .o_rd_item (q_item)
    );

    // day count, seconds arithmetic and output register
    rfue_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_vld (q_rd_vld),
        .o_rd_rdy (b_rd_rdy),
        .i_item   (q_item),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for rtc_fields_to_unix_epoch, clock register requests in,
// epoch seconds out; depends on the rtc_fields_to_unix_epoch sources under hdl

module tb;

    // status register b bits and handy status codes
    localparam int STATUS_BINARY_BIT = 2;
    localparam int STATUS_24H_BIT    = 1;
    localparam int HOUR_PM_BIT       = 7;
    localparam logic [7:0] ST_BCD_12H = 8'h00;
    localparam logic [7:0] ST_BCD_24H = 8'h02;
    localparam logic [7:0] ST_BIN_12H = 8'h04;
    localparam logic [7:0] ST_BIN_24H = 8'h06;

    // cycles with no handshake on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    // one snapshot of the clock chip registers
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] century;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } t_rtc_regs;

    // one converted time
    typedef struct packed {
        logic [37:0] seconds;
        logic        invalid;
    } t_epoch_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;    // seconds, minutes, hours, day, month, year, century
    logic [7:0]  s_axis_tuser  = '0;    // status_b
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // epoch seconds [37:0], two zero pad bits
    logic        m_axis_tuser;          // invalid

    // expected conversions, oldest first
    t_epoch_result epoch_q[$];

    bit century_on  = 1'b0;     // mirror of the century_present register
    bit sender_gaps = 1'b1;     // sender idles between bursts
    bit rx_stalls   = 1'b1;     // receiver stalls on its own pattern
    int hold_left   = 0;        // long receiver hold-off, counted down by the receiver
    int burst_left  = 0;
    int mismatches  = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    rtc_fields_to_unix_epoch DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // calendar helpers
    // ------------------------------------------------------------------

    // gregorian month length, leap february included
    function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
        bit leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mon)
            2:             month_days = leap ? 29 : 28;
            4, 6, 9, 11:   month_days = 30;
            default:       month_days = 31;
        endcase
    endfunction

    // low nibble plus ten times high nibble, digits above 9 pass through the formula
    function automatic int unsigned bcd_value(input int unsigned v);
        bcd_value = (v & 15) + ((v >> 4) & 15) * 10;
    endfunction

    // register byte for a value below 100 in either coding
    function automatic logic [7:0] encode_reg(input int unsigned v, input bit binary);
        encode_reg = binary ? 8'(v) : 8'((v / 10) * 16 + v % 10);
    endfunction

    function automatic t_rtc_regs rtc_regs(input logic [7:0] status, input logic [7:0] cen,
                                           input logic [7:0] yr, input logic [7:0] mon,
                                           input logic [7:0] dd, input logic [7:0] hr,
                                           input logic [7:0] mins, input logic [7:0] secs);
        rtc_regs = '{status: status, century: cen, year: yr, month: mon, day: dd,
                     hours: hr, minutes: mins, seconds: secs};
    endfunction

    // ------------------------------------------------------------------
    // predictor: decode, range check and count seconds since 1970
    // ------------------------------------------------------------------
    function automatic t_epoch_result predict_epoch(input t_rtc_regs r, input bit cen_on);
        int unsigned sec_v, min_v, hour_v, day_v, mon_v, yr_v, cen_v, full_year, prior, m;
        longint unsigned day_count;
        bit bad;
        t_epoch_result res;
        sec_v  = r.seconds;
        min_v  = r.minutes;
        hour_v = r.hours[6:0];                  // pm flag always stripped
        day_v  = r.day;
        mon_v  = r.month;
        yr_v   = r.year;
        cen_v  = cen_on ? r.century : 0;
        if (!r.status[STATUS_BINARY_BIT]) begin
            sec_v  = bcd_value(sec_v);
            min_v  = bcd_value(min_v);
            hour_v = bcd_value(hour_v);
            day_v  = bcd_value(day_v);
            mon_v  = bcd_value(mon_v);
            yr_v   = bcd_value(yr_v);
            cen_v  = bcd_value(cen_v);
        end
        // 12-hour clock: 12 am is midnight, pm adds twelve
        if (!r.status[STATUS_24H_BIT])
            hour_v = hour_v % 12 + (r.hours[HOUR_PM_BIT] ? 12 : 0);
        full_year = (cen_v != 0) ? cen_v * 100 + yr_v : 2000 + yr_v;

        bad = full_year < 1970 || full_year > 9999 || mon_v < 1 || mon_v > 12 ||
              hour_v > 23 || min_v > 59 || sec_v > 59;
        if (!bad && (day_v < 1 || day_v > month_days(mon_v, full_year)))
            bad = 1'b1;

        if (bad) begin
            res.seconds = '0;
            res.invalid = 1'b1;
        end else begin
            // whole years, then whole months, then whole days
            prior = full_year - 1;
            day_count = (full_year - 1970) * 365 + prior / 4 - prior / 100 + prior / 400 - 477;
            for (m = 1; m < mon_v; m++)
                day_count += month_days(m, full_year);
            day_count += day_v - 1;
            res.seconds = 38'(day_count * 86400 + hour_v * 3600 + min_v * 60 + sec_v);
            res.invalid = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generators
    // ------------------------------------------------------------------

    // a real calendar date in a random coding, now and then with one field broken
    function automatic t_rtc_regs make_calendar_request(input bit cen_on);
        t_rtc_regs r;
        int unsigned full_year, yr, cen, mon, dd, hr, hv, pick;
        bit binary, pm;
        r.status = 8'($urandom);
        binary = r.status[STATUS_BINARY_BIT];
        if (cen_on && $urandom_range(0, 9) != 0) begin
            pick = $urandom_range(0, 11);
            case (pick)
                0:       full_year = 1970;
                1:       full_year = 9999;
                2:       full_year = 2000;
                3:       full_year = 2100;
                4:       full_year = 2400;
                default: full_year = $urandom_range(1970, 9999);
            endcase
            cen = full_year / 100;
            yr  = full_year % 100;
            r.century = encode_reg(cen, binary);
            r.year    = encode_reg(yr, binary);
        end else begin
            // century absent or reading zero: 2000 plus the year byte
            yr = (binary && $urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 99);
            full_year = 2000 + yr;
            r.century = cen_on ? 8'h00 : 8'($urandom);
            r.year    = binary ? 8'(yr) : encode_reg(yr, 1'b0);
        end
        mon = $urandom_range(1, 12);
        dd  = ($urandom_range(0, 3) == 0) ? month_days(mon, full_year)
                                          : $urandom_range(1, month_days(mon, full_year));
        hr  = $urandom_range(0, 23);
        r.month   = encode_reg(mon, binary);
        r.day     = encode_reg(dd, binary);
        r.minutes = encode_reg($urandom_range(0, 59), binary);
        r.seconds = encode_reg($urandom_range(0, 59), binary);
        if (r.status[STATUS_24H_BIT]) begin
            hv = hr;
            pm = 1'($urandom);                  // ignored in 24-hour mode
        end else begin
            hv = hr % 12;
            if (hv == 0 && $urandom_range(0, 1) == 1)
                hv = 12;
            pm = hr >= 12;
        end
        r.hours = encode_reg(hv, binary) | {pm, 7'b0};
        // broken sequence: one register replaced by noise
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
                0: r.seconds = 8'($urandom);
                1: r.minutes = 8'($urandom);
                2: r.hours   = 8'($urandom);
                3: r.day     = 8'($urandom);
                4: r.month   = 8'($urandom);
                default: r.year = 8'($urandom);
            endcase
        end
        return r;
    endfunction

    function automatic t_rtc_regs random_registers();
        t_rtc_regs r;
        r = t_rtc_regs'({$urandom, $urandom});
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_request(input t_rtc_regs r);
        if (burst_left == 0) begin
            if (sender_gaps) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.century, r.year, r.month, r.day, r.hours, r.minutes, r.seconds};
        s_axis_tuser  <= r.status;
        do @(posedge i_clk); while (!s_axis_tready);
        // request taken at this edge
        epoch_q.push_back(predict_epoch(r, century_on));
        burst_left--;
    endtask

    // sender pauses until every expected result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (epoch_q.size() != 0);
    endtask

    // century setting is only changed with nothing in flight
    task automatic write_century(input bit on);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        century_on = on;
    endtask

    // ------------------------------------------------------------------
    // receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    int  rx_run  = 0;
    bit  rx_busy = 1'b0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!rx_stalls) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_busy = !rx_busy;
                rx_run  = rx_busy ? $urandom_range(1, 6) : $urandom_range(1, 20);
            end
            rx_run = rx_run - 1;
            m_axis_tready <= !rx_busy;
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_epoch_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (epoch_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d with nothing expected: epoch %0d invalid %b",
                             results_seen, m_axis_tdata, m_axis_tuser);
            end else begin
                want = epoch_q.pop_front();
                if (m_axis_tdata !== {2'b00, want.seconds} || m_axis_tuser !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: expected epoch %0d invalid %b, got epoch %0d invalid %b",
                                 results_seen, want.seconds, want.invalid,
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block is hung
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, both codings, both clock modes, every rejection rule
    task automatic test_directed_dates();
        // century register absent: year is 2000 plus the year byte
        send_request(rtc_regs(ST_BCD_12H, 8'h00, 8'h00, 8'h01, 8'h01, 8'h12, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BIN_24H, 8'h00, 8'd0,  8'd2,  8'd29, 8'd23, 8'd59, 8'd59));
        send_request(rtc_regs(ST_BCD_24H, 8'hFF, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
        // 12 pm is noon, 11 pm is 23
        send_request(rtc_regs(ST_BCD_12H, 8'h00, 8'h24, 8'h06, 8'h15, 8'h92, 8'h15, 8'h30));
        send_request(rtc_regs(ST_BCD_12H, 8'h00, 8'h24, 8'h06, 8'h15, 8'h91, 8'h15, 8'h30));
        // pm flag dropped in 24-hour mode
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h10, 8'h01, 8'h01, 8'h85, 8'h00, 8'h00));
        // bad bcd digits: 0x0f decodes to 15 and passes, 0xfa to 160 and fails
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h0F));
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'hFA));
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h5A, 8'h00));
        // month and day out of range, february 29 in a common year, april 31
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h05, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h05, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h01, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BIN_24H, 8'h00, 8'd7,  8'd4,  8'd31, 8'd0,  8'd0,  8'd0));
        // hour 24 in 24-hour mode, hour 127 wraps in 12-hour binary mode
        send_request(rtc_regs(ST_BIN_24H, 8'h00, 8'd7,  8'd4,  8'd30, 8'd24, 8'd0,  8'd0));
        send_request(rtc_regs(ST_BIN_12H, 8'h00, 8'd7,  8'd4,  8'd30, 8'h7F, 8'd0,  8'd0));
        // all ones, all zeros, largest binary year byte
        send_request(rtc_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(rtc_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BIN_24H, 8'h00, 8'd255, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59));

        // century register present
        write_century(1'b1);
        send_request(rtc_regs(ST_BIN_24H, 8'd19, 8'd70, 8'd1,  8'd1,  8'd0,  8'd0,  8'd0));
        send_request(rtc_regs(ST_BIN_24H, 8'd19, 8'd69, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59));
        send_request(rtc_regs(ST_BIN_24H, 8'd99, 8'd99, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59));
        send_request(rtc_regs(ST_BIN_24H, 8'd100, 8'd0, 8'd1,  8'd1,  8'd0,  8'd0,  8'd0));
        // century reading zero falls back to 2000
        send_request(rtc_regs(ST_BCD_24H, 8'h00, 8'h24, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00));
        // 2100 is not leap, 2400 is
        send_request(rtc_regs(ST_BCD_24H, 8'h21, 8'h00, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));
        send_request(rtc_regs(ST_BIN_24H, 8'd24, 8'd0,  8'd2,  8'd29, 8'd0,  8'd0,  8'd0));
        send_request(rtc_regs(ST_BCD_12H, 8'h19, 8'h99, 8'h12, 8'h31, 8'h91, 8'h59, 8'h59));
    endtask

    // calendar dates with random content, now and then one field broken, century setting flipped between phases
    task automatic test_calendar_sweep();
        int phase, n;
        for (phase = 0; phase < 4; phase++) begin
            write_century(phase[0]);
            for (n = 0; n < 225; n++)
                send_request(make_calendar_request(century_on));
        end
    endtask

    // raw register noise so every bit of every field toggles
    task automatic test_register_noise();
        int n;
        for (n = 0; n < 300; n++) begin
            if (n == 150)
                write_century(!century_on);
            send_request(random_registers());
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        int n;
        sender_gaps = 1'b0;
        hold_left = 300;
        for (n = 0; n < 60; n++)
            send_request(make_calendar_request(century_on));
        drain_results();
        sender_gaps = 1'b1;
    endtask

    // no idling on either side: one request and one result per clock
    task automatic test_full_rate();
        int n;
        write_century(1'b1);
        sender_gaps = 1'b0;
        rx_stalls = 1'b0;
        for (n = 0; n < 150; n++)
            send_request(($urandom_range(0, 3) == 0) ? random_registers()
                                                      : make_calendar_request(century_on));
        sender_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_dates();
        test_calendar_sweep();
        test_register_noise();
        test_output_backpressure();
        test_full_rate();

        // everything back, then an extra wait to catch stray results
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
